### rtl/core/smvp_pkg.sv
// package: shared types, constants and tables of the straight move velocity profile
`timescale 1ns / 1ps
`default_nettype none
package smvp_pkg;

  localparam int TICK_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int VAL_W         = 12;
  localparam int POS_W         = 19;
  localparam int HDG_W         = 16;
  localparam int TURN_W        = 17;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START = 2'd3;

  // sequencer steps, also the datapath commands
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_TEST = 4'd2;
  localparam logic [3:0] OP_SQOP = 4'd3;
  localparam logic [3:0] OP_SQRT = 4'd4;
  localparam logic [3:0] OP_MULA = 4'd5;
  localparam logic [3:0] OP_MULB = 4'd6;
  localparam logic [3:0] OP_DIV  = 4'd7;
  localparam logic [3:0] OP_VSEL = 4'd8;
  localparam logic [3:0] OP_CORD = 4'd9;
  localparam logic [3:0] OP_TURN = 4'd10;
  localparam logic [3:0] OP_OUT  = 4'd11;

  // last step index of each iterative unit
  localparam logic [3:0] SQRT_LAST = 4'd13;
  localparam logic [3:0] DIV_LAST  = 4'd12;
  localparam logic [3:0] CORD_LAST = 4'd15;

  typedef struct packed {
    logic [3:0] op;
    logic [3:0] step;
  } cmd_t;

  typedef struct packed {
    logic finished;
  } stat_t;

  // arctangent of 2^-i in 2^-16 rad
  function automatic logic signed [19:0] atan_lut(input logic [3:0] i);
    logic signed [19:0] a;
    case (i)
      4'd0:    a = 20'sd51472;
      4'd1:    a = 20'sd30386;
      4'd2:    a = 20'sd16055;
      4'd3:    a = 20'sd8150;
      4'd4:    a = 20'sd4091;
      4'd5:    a = 20'sd2047;
      4'd6:    a = 20'sd1024;
      4'd7:    a = 20'sd512;
      4'd8:    a = 20'sd256;
      4'd9:    a = 20'sd128;
      4'd10:   a = 20'sd64;
      4'd11:   a = 20'sd32;
      4'd12:   a = 20'sd16;
      4'd13:   a = 20'sd8;
      4'd14:   a = 20'sd4;
      default: a = 20'sd2;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

### rtl/core/smvp_ctrl.sv
// controller: step sequencer and output handshake of the velocity profile
`timescale 1ns / 1ps
`default_nettype none
module smvp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire smvp_pkg::stat_t stat,
  output smvp_pkg::cmd_t      cmd
);
  import smvp_pkg::*;

  logic [3:0] state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       load_out;

  assign in_ready  = (state_r == OP_NONE);
  assign out_valid = out_valid_r;
  assign load_out  = (state_r == OP_OUT) && (!out_valid_r || out_ready);

  // command to the datapath
  always_comb begin
    cmd.step = cnt_r;
    case (state_r)
      OP_NONE: cmd.op = (in_valid) ? OP_LOAD : OP_NONE;
      OP_OUT:  cmd.op = (load_out) ? OP_OUT : OP_NONE;
      default: cmd.op = state_r;
    endcase
  end

  // next step
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = 4'd0;
    case (state_r)
      OP_NONE: if (in_valid) state_nxt = OP_TEST;
      OP_TEST: state_nxt = OP_SQOP;
      OP_SQOP: state_nxt = (stat.finished) ? OP_OUT : OP_SQRT;
      OP_SQRT: begin
        if (cnt_r == SQRT_LAST) state_nxt = OP_MULA;
        else cnt_nxt = cnt_r + 4'd1;
      end
      OP_MULA: state_nxt = OP_MULB;
      OP_MULB: state_nxt = OP_DIV;
      OP_DIV: begin
        if (cnt_r == DIV_LAST) state_nxt = OP_VSEL;
        else cnt_nxt = cnt_r + 4'd1;
      end
      OP_VSEL: state_nxt = OP_CORD;
      OP_CORD: begin
        if (cnt_r == CORD_LAST) state_nxt = OP_TURN;
        else cnt_nxt = cnt_r + 4'd1;
      end
      OP_TURN: state_nxt = OP_OUT;
      OP_OUT:  if (load_out) state_nxt = OP_NONE;
      default: state_nxt = OP_NONE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= OP_NONE;
      cnt_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/core/smvp_dp.sv
// datapath: config registers, square root, ramp divider, cordic and output registers
`timescale 1ns / 1ps
`default_nettype none
module smvp_dp #(
  parameter int TICK_COUNT_BITS = smvp_pkg::TICK_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire smvp_pkg::cmd_t                         cmd,
  output smvp_pkg::stat_t                             stat,
  input  wire logic                                   cfg_we,
  input  wire logic [smvp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [smvp_pkg::VAL_W-1:0]             cfg_data,
  input  wire logic                                   in_first_tick,
  input  wire logic signed [smvp_pkg::POS_W-1:0]      in_pos_x,
  input  wire logic signed [smvp_pkg::POS_W-1:0]      in_pos_y,
  input  wire logic signed [smvp_pkg::HDG_W-1:0]      in_heading,
  output logic [smvp_pkg::VAL_W-1:0]                  out_speed_target,
  output logic signed [smvp_pkg::TURN_W-1:0]          out_turn_rate_target,
  output logic                                        out_move_done
);
  import smvp_pkg::*;

  localparam logic [TICK_COUNT_BITS-1:0] TICK_MAX = {TICK_COUNT_BITS{1'b1}};

  logic [11:0] dist_r, peak_r, final_r, start_r;
  logic [TICK_COUNT_BITS-1:0] tick_r;
  logic fin_r, first_r;
  logic signed [18:0] px_r, py_r;
  logic signed [15:0] hd_r;
  logic [19:0] mag_r;
  logic [27:0] sq_n_r, sq_r_r;
  logic [23:0] tt_r, dd_r;
  logic [13:0] k_r;
  logic        ramp_en_r;
  logic [37:0] num_r;
  logic [24:0] rem_r;
  logic [12:0] q_r;
  logic [11:0] v_r;
  logic signed [35:0] cx_r, cy_r;
  logic signed [19:0] cz_r;
  logic signed [16:0] turn_r;

  // end test and remaining distance
  logic [TICK_COUNT_BITS-1:0] tick_eff;
  logic fin_eff;
  logic signed [20:0] dist64, limit, extra;
  assign tick_eff = first_r ? '0 : tick_r;
  assign fin_eff  = first_r ? 1'b0 : fin_r;
  assign dist64   = $signed({3'b000, dist_r, 6'b000000});
  assign limit    = dist64 - ((final_r != 12'd0) ? 21'sd768 : 21'sd64);
  assign extra    = dist64 - 21'(px_r);

  // square root step
  logic [27:0] sq_bit, sq_trial;
  logic [4:0]  sq_sh;
  assign sq_sh    = 5'd26 - {cmd.step, 1'b0};
  assign sq_bit   = 28'd1 << sq_sh;
  assign sq_trial = sq_r_r + sq_bit;

  // ramp terms
  logic [11:0] dd, t12;
  assign dd  = peak_r - start_r;
  assign t12 = tick_r[11:0];

  // divider step
  logic [3:0]  dv_i;
  logic [24:0] dv_cur;
  logic [25:0] dv_sh;
  assign dv_i   = 4'd12 - cmd.step;
  assign dv_cur = (cmd.step == 4'd0) ? num_r[37:13] : rem_r;
  assign dv_sh  = {dv_cur, num_r[dv_i]};

  // speed selection and cordic start vector
  logic [13:0] vd, va, vmin;
  logic [11:0] vsel;
  assign vd = sq_r_r[14:1];
  assign va = {2'b00, start_r} + {1'b0, q_r};
  always_comb begin
    vmin = {2'b00, peak_r};
    if (vd < vmin) vmin = vd;
    if (ramp_en_r && (va < vmin)) vmin = va;
    vsel = vmin[11:0];
  end

  // cordic step
  logic signed [35:0] cdx, cdy;
  assign cdx = cy_r >>> cmd.step;
  assign cdy = cx_r >>> cmd.step;

  // rotation scaling, truncation toward zero, saturation
  logic signed [23:0] tdiff, tprod, tq;
  logic signed [16:0] tsat;
  assign tdiff = 24'(cz_r) - (24'(hd_r) <<< 4);
  assign tprod = tdiff * 24'sd5;
  assign tq    = (tprod + ((tprod < 0) ? 24'sd15 : 24'sd0)) >>> 4;
  always_comb begin
    if (tq > 24'sd65535) tsat = 17'sd65535;
    else if (tq < -24'sd65536) tsat = -17'sd65536;
    else tsat = tq[16:0];
  end

  assign stat.finished = fin_r;

  // configuration and move state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r  <= '0;
      peak_r  <= '0;
      final_r <= '0;
      start_r <= '0;
      tick_r  <= '0;
      fin_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DIST:  dist_r  <= cfg_data;
          REG_PEAK:  peak_r  <= cfg_data;
          REG_FINAL: final_r <= cfg_data;
          REG_START: start_r <= cfg_data;
          default:   dist_r  <= dist_r;
        endcase
      end
      if (cmd.op == OP_TEST) begin
        tick_r <= tick_eff;
        fin_r  <= fin_eff | (21'(px_r) > limit);
      end
      if ((cmd.op == OP_OUT) && !fin_r && (tick_r != TICK_MAX)) tick_r <= tick_r + 1'b1;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        first_r <= in_first_tick;
        px_r    <= in_pos_x;
        py_r    <= in_pos_y;
        hd_r    <= in_heading;
      end
      OP_TEST: mag_r <= extra[20] ? 20'(-extra) : extra[19:0];
      OP_SQOP: begin
        sq_n_r <= 28'(mag_r) * 28'd150 + {2'b00, 24'(final_r) * 24'(final_r), 2'b00};
        sq_r_r <= '0;
      end
      OP_SQRT: begin
        if (sq_n_r >= sq_trial) begin
          sq_n_r <= sq_n_r - sq_trial;
          sq_r_r <= (sq_r_r >> 1) + sq_bit;
        end else begin
          sq_r_r <= sq_r_r >> 1;
        end
      end
      OP_MULA: begin
        tt_r      <= t12 * t12;
        dd_r      <= dd * dd;
        k_r       <= 14'(dd) * 14'd3 - {1'b0, t12, 1'b0};
        ramp_en_r <= (peak_r > start_r) && (tick_r < TICK_COUNT_BITS'(dd));
      end
      OP_MULB: num_r <= 38'(tt_r) * 38'(k_r);
      OP_DIV: begin
        if (dv_sh >= {2'b00, dd_r}) begin
          rem_r <= 25'(dv_sh - {2'b00, dd_r});
          q_r   <= {q_r[11:0], 1'b1};
        end else begin
          rem_r <= dv_sh[24:0];
          q_r   <= {q_r[11:0], 1'b0};
        end
      end
      OP_VSEL: begin
        v_r  <= vsel;
        cx_r <= (36'sd19200 + 36'($signed({1'b0, vsel, 5'b00000}))) <<< 8;
        cy_r <= -((36'(py_r) * 36'sd25) <<< 8);
        cz_r <= '0;
      end
      OP_CORD: begin
        if (cy_r > 0) begin
          cx_r <= cx_r + cdx;
          cy_r <= cy_r - cdy;
          cz_r <= cz_r + atan_lut(cmd.step);
        end else begin
          cx_r <= cx_r - cdx;
          cy_r <= cy_r + cdy;
          cz_r <= cz_r - atan_lut(cmd.step);
        end
      end
      OP_TURN: turn_r <= tsat;
      OP_OUT: begin
        out_speed_target     <= fin_r ? final_r : v_r;
        out_turn_rate_target <= fin_r ? 17'sd0 : turn_r;
        out_move_done        <= fin_r;
      end
      default: q_r <= q_r;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/straight_move_velocity_profile.sv
// top level: straight move velocity profile with look-ahead steering
//
// channel | direction | handshake           | payload
// cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
// in      | in        | in_valid/in_ready   | first_tick, pos_x, pos_y, heading
// out     | out       | out_valid/out_ready | speed_target, turn_rate_target, move_done
//
// a request runs through the 14-step square root, the 13-step ramp divider and the
// 16-step cordic, one after another and one request at a time; a request for a
// finished move skips all three and goes straight to the output register.
// a finished result waits in the output register while the next request is worked on.
// synchronous active-low reset clears config, tick count, done flag and handshake state.
// config writes are always taken (cfg_ready high).
`timescale 1ns / 1ps
`default_nettype none
module straight_move_velocity_profile #(
  parameter int TICK_COUNT_BITS = smvp_pkg::TICK_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [smvp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [smvp_pkg::VAL_W-1:0]          cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_first_tick,
  input  wire logic signed [smvp_pkg::POS_W-1:0]   in_pos_x,
  input  wire logic signed [smvp_pkg::POS_W-1:0]   in_pos_y,
  input  wire logic signed [smvp_pkg::HDG_W-1:0]   in_heading,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [smvp_pkg::VAL_W-1:0]               out_speed_target,
  output logic signed [smvp_pkg::TURN_W-1:0]       out_turn_rate_target,
  output logic                                     out_move_done
);
  import smvp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  // sequencer
  smvp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic
  smvp_dp #(
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .cfg_we               (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_first_tick        (in_first_tick),
    .in_pos_x             (in_pos_x),
    .in_pos_y             (in_pos_y),
    .in_heading           (in_heading),
    .out_speed_target     (out_speed_target),
    .out_turn_rate_target (out_turn_rate_target),
    .out_move_done        (out_move_done)
  );

endmodule
`default_nettype wire

### rtl/core/smvp_checker.sv
// checker: port-level properties of the velocity profile, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module smvp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [16:0] out_turn_rate_target,
  input wire logic        out_move_done
);

  // a held result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one request at a time: no new request right after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // a finished move commands no rotation
  a_done_no_turn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_move_done |-> out_turn_rate_target == 17'd0)
    else $error("rotation after move done");

  // a result is never valid in the cycle after its request is taken
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result too early");

endmodule

bind straight_move_velocity_profile smvp_checker u_smvp_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_turn_rate_target (out_turn_rate_target),
  .out_move_done        (out_move_done)
);
`default_nettype wire
